// ----- hdl/audio_rms_level_meter_core_assert.svh -----
// Assertion macros shared by the level meter RTL.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef AUDIO_RMS_LEVEL_METER_CORE_ASSERT_SVH
`define AUDIO_RMS_LEVEL_METER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked on every clock edge outside reset.
`define ARLM_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("level meter assertion failed");
// Checked on every clock edge, also during reset.
`define ARLM_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("level meter assertion failed");
`else
`define ARLM_ASSERT(label, prop)
`define ARLM_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ----- hdl/arlm_pkg.sv -----
`timescale 1ns / 1ps

package arlm_pkg;

  // Field widths of the stream items.
  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 10;
  localparam int SUM_W    = 43;
  localparam int COUNT_W  = 13;

  // Window limit and full-scale level.
  localparam logic [COUNT_W-1:0] MAX_WINDOW = 13'd4096;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 10'd1000;

  // Wide-integer engine: a register of 16-bit limbs multiplied by an operand
  // of up to 43 bits, one limb per cycle.
  localparam int LIMB_W     = 16;
  localparam int NUM_LIMBS  = 13;
  localparam int BIG_W      = LIMB_W * NUM_LIMBS;
  localparam int LIMB_IDX_W = 4;
  localparam int MOP_W      = 43;
  localparam int PROD_W     = LIMB_W + MOP_W;
  localparam int MUL_IDX_W  = 2;

  // Constant factors of the exact level comparison.
  localparam logic [MOP_W-1:0] POW5_12 = 43'd244140625;
  localparam logic [MOP_W-1:0] POW5_18 = 43'd3814697265625;
  localparam logic [BIG_W-1:0] TWO_POW_60 = {{(BIG_W-61){1'b0}}, 1'b1, 60'd0};

  // Burst queue between front and back.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  // One finished burst, handed from the accumulator to the level unit.
  typedef struct packed {
    logic [SUM_W-1:0]   square_sum;
    logic [COUNT_W-1:0] sample_count;
    logic               enable;
  } arlm_burst_t;

endpackage

// ----- hdl/arlm_front.sv -----
`timescale 1ns / 1ps

module arlm_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_data,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [arlm_pkg::SAMPLE_W-1:0] s_tdata,
  input  logic                         s_tlast,
  input  logic                         q_full,
  output logic                         q_push,
  output arlm_pkg::arlm_burst_t        q_entry
);
  import arlm_pkg::*;

  logic                      enable;
  logic [SUM_W-1:0]          square_sum;
  logic [COUNT_W-1:0]        sample_count;
  logic signed [2*SAMPLE_W-1:0] sq_full;
  logic [2*SAMPLE_W-2:0]     sq;
  logic                      take;
  logic                      accept;
  logic [SUM_W-1:0]          sum_upd;
  logic [COUNT_W-1:0]        count_upd;

  // The register port is always ready.
  assign cfg_ready = 1'b1;

  // Items are taken while the burst queue has room.
  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  // Square of the sample; the most negative sample squares to 2^30.
  assign sq_full = $signed(s_tdata) * $signed(s_tdata);
  assign sq      = sq_full[2*SAMPLE_W-2:0];

  // Accumulate only while enabled and the window has room.
  assign take      = enable && (sample_count < MAX_WINDOW);
  assign sum_upd   = take ? square_sum + SUM_W'(sq) : square_sum;
  assign count_upd = take ? sample_count + COUNT_W'(1) : sample_count;

  // A burst end hands the updated totals to the level unit.
  assign q_push                = accept && s_tlast;
  assign q_entry.square_sum    = sum_upd;
  assign q_entry.sample_count  = count_upd;
  assign q_entry.enable        = enable;

  // Enable register and accumulators.
  always_ff @(posedge clk) begin
    if (rst) begin
      enable       <= 1'b0;
      square_sum   <= '0;
      sample_count <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        enable <= cfg_data;
      end
      if (accept) begin
        if (s_tlast) begin
          square_sum   <= '0;
          sample_count <= '0;
        end else begin
          square_sum   <= sum_upd;
          sample_count <= count_upd;
        end
      end
    end
  end

endmodule

// ----- hdl/arlm_queue.sv -----
`timescale 1ns / 1ps
`include "audio_rms_level_meter_core_assert.svh"

module arlm_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  arlm_pkg::arlm_burst_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output logic                  head_valid,
  output arlm_pkg::arlm_burst_t head_entry
);
  import arlm_pkg::*;

  arlm_burst_t        slot [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign full       = (count == Q_CNT_W'(Q_DEPTH));
  assign head_valid = (count != '0);
  assign head_entry = slot[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + Q_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

  `ARLM_ASSERT(a_no_push_when_full, push |-> !full)
  `ARLM_ASSERT(a_no_pop_when_empty, pop |-> head_valid)
  `ARLM_ASSERT(a_pop_drains, (pop && !push) |=> count == $past(count) - Q_CNT_W'(1))

endmodule

// ----- hdl/arlm_level.sv -----
`timescale 1ns / 1ps
`include "audio_rms_level_meter_core_assert.svh"

module arlm_level (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  arlm_pkg::arlm_burst_t q_entry,
  output logic                  q_pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [15:0]           m_tdata
);
  import arlm_pkg::*;

  localparam int SCALED_W = SUM_W + 6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_CUBE,
    ST_RHS_MUL,
    ST_SEARCH,
    ST_SQUARE1,
    ST_SQUARE2,
    ST_LHS_MUL,
    ST_DECIDE,
    ST_DONE
  } state_t;

  state_t                   state;
  logic [SUM_W-1:0]         burst_sum;
  logic [COUNT_W-1:0]       burst_count;
  logic                     burst_en;
  logic [MOP_W-1:0]         s_val;
  logic [2*COUNT_W-1:0]     c_sq;
  logic [MOP_W-1:0]         c_cube;
  logic [LEVEL_W-1:0]       lo;
  logic [LEVEL_W-1:0]       hi;
  logic [LEVEL_W-1:0]       mid;
  logic [2*LEVEL_W-1:0]     l2;
  logic [4*LEVEL_W-1:0]     l4;
  logic [BIG_W-1:0]         acc;
  logic [BIG_W-1:0]         rhs;
  logic [MOP_W-1:0]         carry;
  logic [LIMB_IDX_W-1:0]    limb_cnt;
  logic [MUL_IDX_W-1:0]     mul_idx;
  logic                     le;
  logic [LEVEL_W-1:0]       level;
  logic [LEVEL_W-1:0]       out_level;

  logic [SCALED_W-1:0]      scaled;
  logic [MOP_W-1:0]         full_scale;
  logic [3*COUNT_W-1:0]     cube_prod;
  logic [2*LEVEL_W-1:0]     l2_prod;
  logic [4*LEVEL_W-1:0]     l4_prod;
  logic [LEVEL_W:0]         mid_sum;
  logic [MOP_W-1:0]         m_op;
  logic [LIMB_W-1:0]        limb0;
  logic [LIMB_W-1:0]        rhs0;
  logic [PROD_W-1:0]        prod;
  logic [LIMB_W-1:0]        new_limb;
  logic [BIG_W-1:0]         acc_next;
  logic                     le_next;
  logic                     last_limb;
  logic                     out_free;

  // Ratio terms: 36 * sum against count * 2^30.
  assign scaled     = (SCALED_W'(burst_sum) << 5) + (SCALED_W'(burst_sum) << 2);
  assign full_scale = {burst_count, 30'd0};

  assign cube_prod = c_sq * burst_count;
  assign l2_prod   = mid * mid;
  assign l4_prod   = l2 * l2;
  assign mid_sum   = {1'b0, lo} + {1'b0, hi} + (LEVEL_W+1)'(1);

  // Operand of the current wide multiply.
  always_comb begin
    m_op = s_val;
    if (state == ST_RHS_MUL) begin
      m_op = (mul_idx == '0) ? POW5_18 : s_val;
    end else begin
      unique case (mul_idx)
        2'd0:    m_op = c_cube;
        2'd1:    m_op = MOP_W'(l4);
        2'd2:    m_op = MOP_W'(l4);
        default: m_op = MOP_W'(l2);
      endcase
    end
  end

  // One limb of the wide multiply: low limb times operand plus carry.
  assign limb0     = acc[LIMB_W-1:0];
  assign prod      = PROD_W'(limb0) * PROD_W'(m_op) + PROD_W'(carry);
  assign new_limb  = prod[LIMB_W-1:0];
  assign acc_next  = {new_limb, acc[BIG_W-1:LIMB_W]};
  assign last_limb = (limb_cnt == LIMB_IDX_W'(NUM_LIMBS - 1));

  // The last multiply is compared limb by limb against the rotating bound.
  assign rhs0    = rhs[LIMB_W-1:0];
  assign le_next = (new_limb < rhs0) ? 1'b1 : ((new_limb > rhs0) ? 1'b0 : le);

  // The output data sits in its own register so it holds while an item waits.
  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = {{(16-LEVEL_W){1'b0}}, out_level};

  // Level sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            burst_sum   <= q_entry.square_sum;
            burst_count <= q_entry.sample_count;
            burst_en    <= q_entry.enable;
            state       <= ST_PREP;
          end
        end
        ST_PREP: begin
          // Silent, empty or disabled bursts and clipped levels end here.
          if (!burst_en || burst_count == '0 || burst_sum == '0) begin
            level <= '0;
            state <= ST_DONE;
          end else if (scaled >= SCALED_W'(full_scale)) begin
            level <= LEVEL_MAX;
            state <= ST_DONE;
          end else begin
            s_val <= scaled[MOP_W-1:0];
            c_sq  <= burst_count * burst_count;
            state <= ST_CUBE;
          end
        end
        ST_CUBE: begin
          c_cube   <= MOP_W'(cube_prod);
          acc      <= BIG_W'(POW5_12);
          carry    <= '0;
          limb_cnt <= '0;
          mul_idx  <= '0;
          state    <= ST_RHS_MUL;
        end
        ST_RHS_MUL: begin
          // Bound: 5^30 * scaled^3.
          acc      <= acc_next;
          carry    <= prod[PROD_W-1:LIMB_W];
          limb_cnt <= limb_cnt + LIMB_IDX_W'(1);
          if (last_limb) begin
            carry    <= '0;
            limb_cnt <= '0;
            mul_idx  <= mul_idx + MUL_IDX_W'(1);
            if (mul_idx == '1) begin
              rhs   <= acc_next;
              lo    <= '0;
              hi    <= LEVEL_MAX;
              state <= ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          if (lo == hi) begin
            level <= lo;
            state <= ST_DONE;
          end else begin
            mid   <= mid_sum[LEVEL_W:1];
            state <= ST_SQUARE1;
          end
        end
        ST_SQUARE1: begin
          l2    <= l2_prod;
          state <= ST_SQUARE2;
        end
        ST_SQUARE2: begin
          l4       <= l4_prod;
          acc      <= TWO_POW_60;
          carry    <= '0;
          limb_cnt <= '0;
          mul_idx  <= '0;
          le       <= 1'b1;
          state    <= ST_LHS_MUL;
        end
        ST_LHS_MUL: begin
          // Candidate side: 2^60 * count^3 * mid^10.
          acc      <= acc_next;
          carry    <= prod[PROD_W-1:LIMB_W];
          rhs      <= {rhs0, rhs[BIG_W-1:LIMB_W]};
          limb_cnt <= limb_cnt + LIMB_IDX_W'(1);
          if (mul_idx == '1) begin
            le <= le_next;
          end
          if (last_limb) begin
            carry    <= '0;
            limb_cnt <= '0;
            mul_idx  <= mul_idx + MUL_IDX_W'(1);
            if (mul_idx == '1) begin
              state <= ST_DECIDE;
            end
          end
        end
        ST_DECIDE: begin
          if (le) begin
            lo <= mid;
          end else begin
            hi <= mid - LEVEL_W'(1);
          end
          state <= ST_SEARCH;
        end
        ST_DONE: begin
          if (out_free) begin
            m_tvalid  <= 1'b1;
            out_level <= level;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ARLM_ASSERT(a_level_range, m_tvalid |-> out_level <= LEVEL_MAX)
  `ARLM_ASSERT(a_search_order, (state == ST_SEARCH) |-> lo <= hi)
  `ARLM_ASSERT(a_search_bound, (state == ST_SEARCH) |-> hi <= LEVEL_MAX)
  `ARLM_ASSERT(a_done_delivers, (state == ST_DONE && out_free) |=> m_tvalid)

endmodule

// ----- hdl/audio_rms_level_meter_core.sv -----
`timescale 1ns / 1ps

// RMS level meter. Signed 16-bit samples stream in on s_*, the last sample
// of each burst marked by s_tlast; for every burst the block returns one
// level on m_* in thousandths, the largest L in 0..1000 with
// (L/1000)^10 <= (36*meansq/2^30)^3, so 1000*min(1, 6*rms)^0.6 floored,
// computed exactly. At most 4096 samples per burst are counted; later ones
// are ignored. With enable at 0 (the reset value) nothing is accumulated
// and every burst end returns 0. Samples are taken one per cycle while the
// burst queue has room; while it is full, s_tready is low. Each burst end
// is queued (four deep) for the level unit, which takes one at a time,
// multiplies a 208-bit integer one 16-bit limb per cycle and searches the
// level by bisection; silent, disabled or clipped bursts skip both.
module audio_rms_level_meter_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_data,   // enable
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [arlm_pkg::SAMPLE_W-1:0] s_tdata,    // [15:0] sample
  input  logic                          s_tlast,    // burst_end
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [15:0]                   m_tdata     // [9:0] level, zero above
);
  import arlm_pkg::*;

  arlm_burst_t push_entry;
  arlm_burst_t head_entry;
  logic        push;
  logic        full;
  logic        pop;
  logic        head_valid;

  // Sample accumulation and register port.
  arlm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .q_full    (full),
    .q_push    (push),
    .q_entry   (push_entry)
  );

  // Finished bursts waiting for the level unit.
  arlm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  // Level computation and output register.
  arlm_level u_level (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (head_valid),
    .q_entry  (head_entry),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ----- sim/level_meter_checker.sv -----
`timescale 1ns / 1ps

// Watches the enable, sample and level channels of the meter, keeps its own
// copy of the burst sums and predicts the level of every finished burst.
// Levels are compared in order against the oldest prediction.
module level_meter_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic                          cfg_data,   // enable
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [arlm_pkg::SAMPLE_W-1:0] s_tdata,    // [15:0] sample
  input  logic                          s_tlast,    // burst_end
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [15:0]                   m_tdata,    // [9:0] level
  output int                            mismatches,
  output int                            levels_waiting,
  output int                            levels_checked,
  output int                            full_scale_seen,
  output int                            silent_seen
);
  import arlm_pkg::*;

  // Shadow state of the meter.
  logic               meter_on  = 1'b0;
  logic [SUM_W-1:0]   acc_sum   = '0;
  logic [COUNT_W-1:0] acc_count = '0;
  logic [LEVEL_W-1:0] level_q[$];
  int                 err_cnt   = 0;
  int                 n_checked = 0;
  int                 n_full    = 0;
  int                 n_silent  = 0;

  // Largest L in 0..1000 with L^10 * (count*2^30)^3 <= (36*sum)^3 * 10^30.
  // Both sides fit in 256 bits, so the search is exact.
  function automatic logic [LEVEL_W-1:0] burst_level(input logic [SUM_W-1:0]   sum,
                                                     input logic [COUNT_W-1:0] cnt);
    logic [255:0] scaled, full_sc, bound, probe, dec_scale;
    int unsigned  lo, hi, mid;
    int           k;
    if (cnt == '0 || sum == '0) return '0;
    scaled  = 256'(sum) * 256'd36;
    full_sc = 256'(cnt) << 30;
    if (scaled >= full_sc) return LEVEL_MAX;
    dec_scale = 256'd1;
    for (k = 0; k < 30; k++) dec_scale = dec_scale * 256'd10;
    bound = scaled * scaled * scaled * dec_scale;
    lo = 0;
    hi = 1000;
    while (lo < hi) begin
      mid   = (lo + hi + 1) / 2;
      probe = 256'd1;
      for (k = 0; k < 10; k++) probe = probe * 256'(mid);
      probe = probe * full_sc * full_sc * full_sc;
      if (probe <= bound) lo = mid;
      else hi = mid - 1;
    end
    return lo[LEVEL_W-1:0];
  endfunction

  always @(posedge clk) begin : observe
    logic [15:0]        mag;
    logic [SUM_W-1:0]   sq;
    logic [LEVEL_W-1:0] want, got;
    if (rst) begin
      meter_on  = 1'b0;
      acc_sum   = '0;
      acc_count = '0;
      level_q.delete();
    end else begin
      // Levels are handled first: a burst that ends at this edge cannot be answered yet.
      if (m_tvalid && m_tready) begin
        got = m_tdata[LEVEL_W-1:0];
        if (level_q.size() == 0) begin
          $error("level: expected no item, actual %0d", got);
          err_cnt++;
        end else begin
          want = level_q.pop_front();
          if (got !== want) begin
            $error("level: expected %0d, actual %0d", want, got);
            err_cnt++;
          end
          n_checked++;
          if (want == LEVEL_MAX) n_full++;
          if (want == '0) n_silent++;
        end
      end

      // Accumulate the square of the magnitude while the window has room.
      // A sample taken at the edge of an enable write still sees the old enable.
      if (s_tvalid && s_tready) begin
        mag = s_tdata[15] ? ~s_tdata + 16'd1 : s_tdata;
        sq  = mag;
        if (meter_on && acc_count < MAX_WINDOW) begin
          acc_sum   = acc_sum + sq * sq;
          acc_count = acc_count + 1'b1;
        end
        if (s_tlast) begin
          level_q.push_back(meter_on ? burst_level(acc_sum, acc_count) : '0);
          acc_sum   = '0;
          acc_count = '0;
        end
      end

      // Enable register writes.
      if (cfg_valid && cfg_ready) meter_on = cfg_data;
    end
    mismatches      <= err_cnt;
    levels_waiting  <= level_q.size();
    levels_checked  <= n_checked;
    full_scale_seen <= n_full;
    silent_seen     <= n_silent;
  end

endmodule

// ----- sim/audio_rms_level_meter_core_tb.sv -----
`timescale 1ns / 1ps

module audio_rms_level_meter_core_tb;
  import arlm_pkg::*;

  localparam int   RANDOM_ITEMS  = 1700;
  localparam int   PHASE_ITEMS   = 300;
  localparam int   CALM_ITEMS    = 150;
  localparam int   SETTLE_CYCLES = 16;
  localparam int   DRAIN_CYCLES  = 800;
  localparam int   LONG_HOLD     = 3000;
  localparam int   WINDOW_BURST  = 4100;
  localparam logic METER_OFF     = 1'b0;
  localparam logic METER_ON      = 1'b1;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_data  = 1'b0;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [SAMPLE_W-1:0] s_tdata   = '0;
  logic                s_tlast   = 1'b0;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [15:0]         m_tdata;

  int mismatches, levels_waiting, levels_checked, full_scale_seen, silent_seen;
  int samples_sent  = 0;
  int enable_writes = 0;
  bit hold_req      = 1'b0;
  bit tx_calm       = 1'b0;
  bit rx_calm       = 1'b0;

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  audio_rms_level_meter_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  level_meter_checker level_check (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tlast         (s_tlast),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .mismatches      (mismatches),
    .levels_waiting  (levels_waiting),
    .levels_checked  (levels_checked),
    .full_scale_seen (full_scale_seen),
    .silent_seen     (silent_seen)
  );

  // Offers one sample item, after an optional idle burst, and waits until it is taken.
  // The valid stays high afterwards so that the next item can follow without a gap.
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic last);
    int gap;
    if (!tx_calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    samples_sent++;
  endtask

  // Stops offering samples and waits until every burst level has come back.
  task automatic drain_levels();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (levels_waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the enable register; only called while the meter is idle.
  task automatic write_enable(input logic en);
    cfg_valid <= 1'b1;
    cfg_data  <= en;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    enable_writes++;
  endtask

  // Level sink: random stalls, one long hold on request, none near the end.
  initial begin : level_sink
    int stall;
    int run;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        for (stall = 0; stall < LONG_HOLD; stall++) @(posedge clk);
      end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      m_tready <= 1'b1;
      run = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 100) : 1;
      repeat (run) @(posedge clk);
    end
  end

  initial begin : stimulus
    int                  burst_left;
    int                  amp;
    int                  phase;
    logic                dc_burst;
    logic [SAMPLE_W-1:0] raw;
    logic [SAMPLE_W-1:0] dc_value;
    logic [SAMPLE_W-1:0] smp;
    logic signed [15:0]  shaped;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Disabled after reset: the burst end reports zero and clears the sums.
    send_sample(16'h7fff, 1'b0);
    send_sample(16'h8000, 1'b1);
    drain_levels();
    write_enable(METER_ON);

    // Silence, full scale of either sign and the smallest nonzero magnitudes.
    send_sample(16'h0000, 1'b1);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h7fff, 1'b1);
    send_sample(16'h0001, 1'b1);
    send_sample(16'hffff, 1'b1);

    // Just below and just at the point where the level clips to full scale.
    send_sample(16'd5461, 1'b1);
    send_sample(16'heaaa, 1'b1);

    // Enable dropped inside a burst: the samples taken so far stay, and
    // accumulation picks up again when enable returns.
    send_sample(16'd1000, 1'b0);
    send_sample(16'hf830, 1'b0);
    drain_levels();
    write_enable(METER_OFF);
    send_sample(16'd30000, 1'b0);
    send_sample(16'h8ad0, 1'b0);
    drain_levels();
    write_enable(METER_ON);
    send_sample(16'd3000, 1'b1);

    // Window full: loud samples after the first 4096 of a burst, the burst end
    // among them, must not count.
    for (int n = 0; n < WINDOW_BURST; n++) begin
      smp = (n < 4096) ? (n[0] ? 16'd100 : 16'hff9c) : 16'h8000;
      send_sample(smp, n == WINDOW_BURST - 1);
    end
    drain_levels();

    // Long hold on the level side while short bursts keep coming, so the
    // burst queue fills and the sample input stalls.
    hold_req = 1'b1;
    tx_calm  = 1'b1;
    for (int b = 0; b < 16; b++) begin
      for (int n = 0; n < 3; n++) begin
        raw    = SAMPLE_W'($urandom);
        shaped = $signed(raw) >>> $urandom_range(1, 8);
        send_sample(shaped, n == 2);
      end
    end
    tx_calm = 1'b0;
    drain_levels();

    // Random bursts. Phase boundaries fall anywhere, also inside a burst,
    // and one phase runs with the meter disabled.
    burst_left = 0;
    phase      = 0;
    dc_burst   = 1'b0;
    dc_value   = '0;
    amp        = 15;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i > 0 && i % PHASE_ITEMS == 0) begin
        drain_levels();
        phase++;
        write_enable(phase == 2 ? METER_OFF : METER_ON);
      end
      if (i == RANDOM_ITEMS - CALM_ITEMS) begin
        tx_calm = 1'b1;
        rx_calm = 1'b1;
      end
      raw    = SAMPLE_W'($urandom);
      shaped = $signed(raw) >>> (15 - amp);
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 200)
                                                  : $urandom_range(1, 24);
        amp      = $urandom_range(0, 15);
        dc_burst = ($urandom_range(0, 7) == 0);
        case ($urandom_range(0, 3))
          0:       dc_value = 16'h0000;
          1:       dc_value = 16'h8000;
          2:       dc_value = 16'h7fff;
          default: dc_value = shaped;
        endcase
        shaped = $signed(raw) >>> (15 - amp);
      end
      smp = dc_burst ? dc_value : shaped;
      if (i == RANDOM_ITEMS - 1) burst_left = 1;
      send_sample(smp, burst_left == 1);
      burst_left--;
    end

    // Wait for the last levels, then a little longer for any stray item.
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (levels_waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d samples in bursts from one sample to past the 4096-sample window, %0d enable writes.",
             samples_sent, enable_writes);
    $display("Compared %0d levels: %0d at full scale, %0d at zero, the rest in between.",
             levels_checked, full_scale_seen, silent_seen);
    if (mismatches == 0 && levels_waiting == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard limit on the run time.
  initial begin : run_limit
    #100_000_000;
    $display("Run limit reached with %0d levels outstanding.", levels_waiting);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
